// File: sv/sha256_message_digest_unit_defines.svh
// Assertion macros for the digest unit checker
`ifndef SHA256_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SHA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sha_pkg.sv
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // front to back command: byte and/or end marker, already filtered
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_end;
    } sha_cmd_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] ror(input logic [31:0] x, input int r);
        ror = (x >> r) | (x << (32 - r));
    endfunction

endpackage
`default_nettype wire

// File: sv/sha_front.sv
`default_nettype none
// Input filter and command queue.
module sha_front import sha_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire sha_in_t  s_item,
    input  wire logic     s_valid,
    output logic          s_ready,
    output sha_cmd_t      q_cmd,
    output logic          q_valid,
    input  wire logic     q_ready
);
    sha_cmd_t mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic useful, push, pop;

    // items with neither byte nor end are dropped here
    assign useful  = s_item.byte_present | s_item.end_of_message;
    assign s_ready = (cnt_reg != (QAW+1)'(QDEPTH));
    assign push    = s_valid & s_ready & useful;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid & q_ready;
    assign q_cmd   = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= '{data_byte: s_item.data_byte,
                             has_byte: s_item.byte_present,
                             is_end: s_item.end_of_message};
        end
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// File: sv/sha_core.sv
`default_nettype none
// Byte packer, padding sequencer, round engine and digest output.
module sha_core import sha_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire sha_cmd_t q_cmd,
    input  wire logic     q_valid,
    output logic          q_ready,
    output sha_out_t      m_item,
    output logic          m_valid,
    input  wire logic     m_ready
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_PAD = 3'd1, ST_LEN = 3'd2,
                           ST_RND = 3'd3, ST_ADD = 3'd4, ST_OUT = 3'd5;

    logic [2:0]  st_reg, st_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg, lensnap_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  lidx_reg;
    logic        ending_reg, pad1_reg;
    logic [2:0]  oidx_reg;
    // length field written means the message block is complete
    logic        lendone_reg;

    logic        put;
    logic [7:0]  pbyte;
    logic [31:0] wt, wnew, t1, t2, e, a;

    // byte source for this cycle
    always_comb begin
        put = 1'b0; pbyte = 8'h00; q_ready = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                put = q_valid & q_cmd.has_byte;
                pbyte = q_cmd.data_byte;
            end
            ST_PAD: begin
                put = 1'b1;
                pbyte = pad1_reg ? PAD_BYTE : 8'h00;
            end
            ST_LEN: begin
                put = 1'b1;
                pbyte = lensnap_reg[8*(7-lidx_reg) +: 8];
            end
            default: ;
        endcase
    end

    // schedule: window shifts one word each round
    assign wnew = w_reg[0] + (ror(w_reg[1],7) ^ ror(w_reg[1],18) ^ (w_reg[1] >> 3))
                + w_reg[9] + (ror(w_reg[14],17) ^ ror(w_reg[14],19) ^ (w_reg[14] >> 10));
    assign wt = (rnd_reg < 6'd16) ? w_reg[0] : wnew;
    assign e  = v_reg[4];
    assign a  = v_reg[0];
    assign t1 = v_reg[7] + (ror(e,6) ^ ror(e,11) ^ ror(e,25))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[rnd_reg] + wt;
    assign t2 = (ror(a,2) ^ ror(a,13) ^ ror(a,22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (q_valid) begin
                if (put && fill_reg == 6'd63) st_next = ST_RND;
                else if (q_cmd.is_end)        st_next = ST_PAD;
            end
            ST_PAD: begin
                if (fill_reg == 6'd63)          st_next = ST_RND;
                else if (fill_reg == LEN_POS - 6'd1) st_next = ST_LEN;
            end
            ST_LEN: if (lidx_reg == 3'd7) st_next = ST_RND;
            ST_RND: if (rnd_reg == 6'd63) st_next = ST_ADD;
            ST_ADD: begin
                if (ending_reg) st_next = lendone_reg ? ST_OUT : ST_PAD;
                else            st_next = ST_IDLE;
            end
            ST_OUT: if (m_ready && oidx_reg == 3'd7) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    assign m_valid = (st_reg == ST_OUT);
    assign m_item  = '{digest_word: h_reg[oidx_reg], word_index: oidx_reg,
                       last_word: (oidx_reg == 3'd7)};

    always_ff @(posedge aclk) begin
        if (put) begin
            w_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= pbyte;
        end
        if (st_reg == ST_RND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wt;
            v_reg[0] <= t1 + t2; v_reg[1] <= v_reg[0]; v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2]; v_reg[4] <= v_reg[3] + t1; v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5]; v_reg[7] <= v_reg[6];
        end else begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end
        if (st_reg == ST_IDLE && q_valid && q_cmd.is_end)
            lensnap_reg <= len_reg + (q_cmd.has_byte ? 64'd8 : 64'd0);
        if (!aresetn) begin
            st_reg <= ST_IDLE; fill_reg <= '0; len_reg <= '0; rnd_reg <= '0;
            lidx_reg <= '0; ending_reg <= 1'b0; pad1_reg <= 1'b0; oidx_reg <= '0;
            lendone_reg <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
        end else begin
            st_reg <= st_next;
            if (put) fill_reg <= fill_reg + 6'd1;
            case (st_reg)
                ST_IDLE: if (q_valid) begin
                    if (q_cmd.has_byte) len_reg <= len_reg + 64'd8;
                    ending_reg  <= q_cmd.is_end;
                    pad1_reg    <= 1'b1;
                    lendone_reg <= 1'b0;
                end
                ST_PAD: pad1_reg <= 1'b0;
                ST_LEN: begin
                    lidx_reg <= lidx_reg + 3'd1;
                    if (lidx_reg == 3'd7) lendone_reg <= 1'b1;
                end
                ST_RND: rnd_reg <= rnd_reg + 6'd1;
                ST_ADD: for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                ST_OUT: if (m_ready) begin
                    oidx_reg <= oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
                        len_reg <= '0; ending_reg <= 1'b0; lendone_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/sha256_message_digest_unit.sv
// SHA-256 digest unit. Message bytes arrive one per transfer on s_; a
// transfer with end_of_message set (with or without a byte) closes the
// message, and eight digest words H0..H7 leave on m_, last_word on H7.
// Transfers with neither flag are dropped. A four-entry queue decouples
// intake from the compression engine, which runs one round per cycle:
// each 64-byte block is packed byte by byte from the queue, and intake
// stalls while its 64 rounds and the chaining add run. Message
// end costs padding bytes at one per cycle, one or two compressions, and
// eight output transfers. The unit then returns to the initial hash state.
`default_nettype none
module sha256_message_digest_unit import sha_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire sha_in_t  s_item,
    input  wire logic     s_valid,
    output logic          s_ready,
    output sha_out_t      m_item,
    output logic          m_valid,
    input  wire logic     m_ready
);
    sha_cmd_t q_cmd;
    logic     q_valid, q_ready;

    sha_front u_front (.aclk, .aresetn, .s_item, .s_valid, .s_ready,
                       .q_cmd, .q_valid, .q_ready);
    sha_core  u_core  (.aclk, .aresetn, .q_cmd, .q_valid, .q_ready,
                       .m_item, .m_valid, .m_ready);
endmodule
`default_nettype wire

// File: sv/sha_checker.sv
`default_nettype none
`include "sha256_message_digest_unit_defines.svh"
module sha_checker import sha_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire sha_out_t m_item,
    input wire logic     m_valid,
    input wire logic     m_ready
);
    `SHA_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "m held")
    `SHA_ASSERT_IMP(a_last, aclk, aresetn, m_valid, m_item.last_word == (m_item.word_index == 3'd7), "last")
    `SHA_ASSERT_NXT(a_seq, aclk, aresetn, m_valid && m_ready && !m_item.last_word, m_valid && m_item.word_index == $past(m_item.word_index) + 3'd1, "order")
endmodule
bind sha256_message_digest_unit sha_checker u_chk (.aclk, .aresetn,
    .m_item, .m_valid, .m_ready);
`default_nettype wire

// File: verif/sha256_message_digest_unit_tb.sv
`default_nettype none
module sha256_message_digest_unit_tb;
    import sha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    sha_in_t  s_item = '0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sha_out_t m_item;
    logic     m_valid;
    logic     m_ready = 1'b0;

    always #5 aclk = ~aclk;

    sha256_message_digest_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_item(s_item), .s_valid(s_valid), .s_ready(s_ready),
        .m_item(m_item), .m_valid(m_valid), .m_ready(m_ready)
    );

    // Hashing state mirrored in the testbench
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] msg_bits;

    sha_in_t  pending_items [$];
    sha_out_t digest_words_due [$];
    int       error_count = 0;
    bit       stimulus_done = 1'b0;
    bit       calm_phase = 1'b0;   // no idling on either side
    int       quiet_cycles = 0;
    int       send_gap = 0;
    bit       s_ready_seen = 1'b0;

    function automatic logic [31:0] rot_r(input logic [31:0] x, input int r);
        return (x >> r) | (x << (32 - r));
    endfunction

    function automatic void compress_msg_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, s0, s1, t1, t2, x15, x2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 0; t < 8; t++) v[t] = hash_state[t];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                x15 = w[(t + 1) & 15];
                x2  = w[(t + 14) & 15];
                s0 = rot_r(x15, 7) ^ rot_r(x15, 18) ^ (x15 >> 3);
                s1 = rot_r(x2, 17) ^ rot_r(x2, 19) ^ (x2 >> 10);
                wt = w[t & 15] + s0 + w[(t + 9) & 15] + s1;
                w[t & 15] = wt;
            end
            t1 = v[7] + (rot_r(v[4], 6) ^ rot_r(v[4], 11) ^ rot_r(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
            t2 = (rot_r(v[0], 2) ^ rot_r(v[0], 13) ^ rot_r(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) hash_state[t] += v[t];
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            compress_msg_block();
            block_fill = 0;
        end
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
        block_fill = 0;
        msg_bits = '0;
    endfunction

    // Update the mirror for one accepted transfer; on message end queue the digest
    function automatic void predict_digest(input sha_in_t it);
        logic [63:0] len;
        sha_out_t    o;
        if (it.byte_present) begin
            msg_bits += 64'd8;
            append_byte(it.data_byte);
        end
        if (!it.end_of_message) return;
        len = msg_bits;
        append_byte(PAD_BYTE);
        while (block_fill != LEN_POS) append_byte(8'h00);
        for (int i = 0; i < 8; i++) append_byte(len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
            o.digest_word = hash_state[i];
            o.word_index  = 3'(i);
            o.last_word   = (i == 7);
            digest_words_due.push_back(o);
        end
        restart_hash();
    endfunction

    function automatic sha_in_t make_item(input logic [7:0] d, input bit p, input bit e);
        sha_in_t it;
        it.data_byte = d; it.byte_present = p; it.end_of_message = e;
        return it;
    endfunction

    // Random message: bytes then an end marker that may or may not carry one.
    // Lengths mostly short, a few long enough to cross block boundaries.
    task automatic queue_message(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b0)); // dropped
            pending_items.push_back(make_item(8'($urandom), 1'b1, 1'b0));
        end
        pending_items.push_back(make_item(8'($urandom), 1'($urandom), 1'b1));
    endtask

    initial begin
        restart_hash();
        // Directed: empty message, "abc", extremes, end with and without byte,
        // padding lengths around the 56-byte boundary, some forcing a second block.
        pending_items.push_back(make_item(8'hff, 1'b0, 1'b1));
        pending_items.push_back(make_item(8'h61, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h62, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h63, 1'b1, 1'b1));
        pending_items.push_back(make_item(8'h00, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'hff, 1'b0, 1'b0)); // ignored
        pending_items.push_back(make_item(8'hff, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
        for (int i = 0; i < 55; i++)
            pending_items.push_back(make_item(8'($urandom), 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h80, 1'b1, 1'b1)); // 56 bytes
        queue_message(55);
        queue_message(63);
        queue_message(64);
        while (pending_items.size() < 410) begin
            if (pending_items.size() < 280 && $urandom_range(0, 9) == 0)
                queue_message($urandom_range(100, 140));
            else queue_message($urandom_range(0, 20));
        end
    end

    // Sender: valid asserted at the falling edge, holds until accepted
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_seen) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_item  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    if (!calm_phase && $urandom_range(0, 4) == 0)
                        send_gap <= $urandom_range(1, 3);
                end else begin
                    s_valid       <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Receiver: random bursts of holding off, one long hold early on
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && digest_words_due.size() > 0 && pending_items.size() < 380) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm_phase) begin
                m_ready <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 3);
            end
        end
    end

    // Monitor: everything sampled at the rising edge
    always @(posedge aclk) begin
        s_ready_seen <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (pending_items.size() < 60) calm_phase <= 1'b1;
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (s_valid && s_ready) predict_digest(s_item);
            if (m_valid && m_ready) begin
                if (digest_words_due.size() == 0) begin
                    $error("digest word with nothing expected: %h", m_item.digest_word);
                    error_count++;
                end else begin
                    sha_out_t exp_w;
                    exp_w = digest_words_due.pop_front();
                    if (m_item.digest_word !== exp_w.digest_word) begin
                        $error("digest_word expected %h actual %h",
                               exp_w.digest_word, m_item.digest_word);
                        error_count++;
                    end
                    if (m_item.word_index !== exp_w.word_index) begin
                        $error("word_index expected %0d actual %0d",
                               exp_w.word_index, m_item.word_index);
                        error_count++;
                    end
                    if (m_item.last_word !== exp_w.last_word) begin
                        $error("last_word expected %0d actual %0d",
                               exp_w.last_word, m_item.last_word);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;
        fork
            begin
                wait (stimulus_done && digest_words_due.size() == 0);
                repeat (200) @(posedge aclk);
            end
            begin
                wait (quiet_cycles >= WATCHDOG_LIMIT);
            end
        join_any
        if (quiet_cycles < WATCHDOG_LIMIT && error_count == 0 &&
            digest_words_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
